// File: hdl/es2utc_pkg.sv
// es2utc_pkg: types and constants shared by the epoch-seconds to UTC calendar block.
// No dependencies; compiled first.
package es2utc_pkg;

    // Reciprocals for division by constants: q = (x * C) >> S, exact over the value ranges used.
    localparam logic [31:0] C_DIV60_A   = 32'd2290649225;  // seconds / 60, shift 37
    localparam int          S_DIV60_A   = 37;
    localparam logic [25:0] C_DIV60_B   = 26'd35791395;    // minutes / 60, shift 31
    localparam int          S_DIV60_B   = 31;
    localparam logic [15:0] C_DIV3      = 16'd43691;       // (hours / 8) / 3, shift 17
    localparam int          S_DIV3      = 17;
    localparam logic [15:0] C_DIV1461   = 16'd45934;       // days / 1461, shift 26
    localparam int          S_DIV1461   = 26;
    localparam logic [15:0] C_DIV7      = 16'd37450;       // days / 7, shift 18
    localparam int          S_DIV7      = 18;

    localparam int DAY_W = 15;   // days since 1968-01-01 stay below 2^15

    localparam logic [14:0] DAYS_1968_TO_1970 = 15'd731;
    localparam logic [14:0] DAYS_4Y            = 15'd1461;
    localparam logic [7:0]  YEAR_1968          = 8'd68;
    localparam logic [8:0]  FEB29_YDAY         = 9'd59;
    // 1968 is leap; every year in range that is a multiple of four is leap (2000 included)
    localparam logic [10:0] END_Y0 = 11'd366;
    localparam logic [10:0] END_Y1 = 11'd731;
    localparam logic [10:0] END_Y2 = 11'd1096;

    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hr;
    } t_hms;

    typedef struct packed {
        logic [DAY_W-1:0] days;   // days since 1968-01-01
        t_hms             hms;
    } t_day_word;

    typedef struct packed {
        t_hms       hms;
        logic [2:0] wday;
        logic [7:0] year;
        logic [8:0] yday;
        logic [3:0] mon;
        logic [4:0] mday;
    } t_cal;

    // first day of each month in a leap year
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] d;
        unique case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd60;
            4'd3:    d = 9'd91;
            4'd4:    d = 9'd121;
            4'd5:    d = 9'd152;
            4'd6:    d = 9'd182;
            4'd7:    d = 9'd213;
            4'd8:    d = 9'd244;
            4'd9:    d = 9'd274;
            4'd10:   d = 9'd305;
            4'd11:   d = 9'd335;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// File: hdl/es2utc_if.sv
// es2utc_if: valid/ready channels of the calendar block.
// Input channel carries epoch seconds, output channel carries the calendar fields.
interface es2utc_in_if;
    logic        valid;
    logic        ready;
    logic [30:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface es2utc_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [7:0] years_since_1900;
    logic [8:0] day_of_year;
    logic [3:0] month_index;
    logic [4:0] day_of_month;

    modport source (output valid, output second, output minute, output hour,
                    output weekday, output years_since_1900, output day_of_year,
                    output month_index, output day_of_month, input ready);
    modport sink   (input valid, input second, input minute, input hour,
                    input weekday, input years_since_1900, input day_of_year,
                    input month_index, input day_of_month, output ready);
endinterface

// File: hdl/es2utc_date.sv
// es2utc_date: five-stage pipeline from day count (since 1968-01-01) to weekday,
// year, day of year, month and day of month. Depends on es2utc_pkg.
module es2utc_date (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  es2utc_pkg::t_day_word i_word,
    output logic                  o_valid,
    input  logic                  i_ready,
    output es2utc_pkg::t_cal      o_cal
);
    import es2utc_pkg::*;

    localparam int NSTG = 5;

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] w_en;

    always_comb begin
        w_en[NSTG-1] = !r_v[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 1: 4-year cycle index and week count
    logic [DAY_W-1:0] w_dp2;
    logic [30:0]      w_p4;
    logic [30:0]      w_pw;
    logic [DAY_W-1:0] r1_days;
    logic [DAY_W-1:0] r1_dp2;
    logic [4:0]       r1_q4;
    logic [12:0]      r1_wq;
    t_hms             r1_hms;

    assign w_dp2 = i_word.days + DAY_W'(1);   // 1968-01-01 was a Monday
    assign w_p4  = 31'(i_word.days) * 31'(C_DIV1461);
    assign w_pw  = 31'(w_dp2) * 31'(C_DIV7);

    // stage 2: day within the 4-year cycle, weekday
    logic [DAY_W-1:0] w_base;
    logic [10:0]      r2_r;
    logic [4:0]       r2_q4;
    logic [2:0]       r2_wday;
    t_hms             r2_hms;

    assign w_base = 15'({10'd0, r1_q4}) * DAYS_4Y;

    // stage 3: year within the cycle and day of year
    logic       w_leap;
    logic [1:0] w_yoff;
    logic [8:0] w_yday;
    logic [7:0] r3_year;
    logic [8:0] r3_yday;
    logic       r3_leap;
    logic [2:0] r3_wday;
    t_hms       r3_hms;

    always_comb begin
        priority if (r2_r < END_Y0) begin
            w_leap = 1'b1;
            w_yoff = 2'd0;
            w_yday = r2_r[8:0];
        end else if (r2_r < END_Y1) begin
            w_leap = 1'b0;
            w_yoff = 2'd1;
            w_yday = 9'(r2_r - END_Y0);
        end else if (r2_r < END_Y2) begin
            w_leap = 1'b0;
            w_yoff = 2'd2;
            w_yday = 9'(r2_r - END_Y1);
        end else begin
            w_leap = 1'b0;
            w_yoff = 2'd3;
            w_yday = 9'(r2_r - END_Y2);
        end
    end

    // stage 4: month from leap-year table, common years skip Feb 29
    logic [8:0] w_adj;
    logic [3:0] w_mon;
    logic [8:0] r4_adj;
    logic [3:0] r4_mon;
    logic [7:0] r4_year;
    logic [8:0] r4_yday;
    logic [2:0] r4_wday;
    t_hms       r4_hms;

    assign w_adj = r3_yday + 9'((!r3_leap && r3_yday >= FEB29_YDAY) ? 1 : 0);

    always_comb begin
        w_mon = 4'd0;
        for (int m = 1; m < 12; m++) begin
            if (w_adj >= month_start(4'(m))) w_mon = 4'(m);
        end
    end

    // stage 5: output register
    t_cal r5_cal;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_days <= i_word.days;
            r1_dp2  <= w_dp2;
            r1_q4   <= w_p4[30:S_DIV1461];
            r1_wq   <= w_pw[30:S_DIV7];
            r1_hms  <= i_word.hms;
        end
        if (w_en[1]) begin
            r2_r    <= 11'(r1_days - w_base);
            r2_q4   <= r1_q4;
            r2_wday <= r1_dp2[2:0] + r1_wq[2:0];   // x - 7q == x + q mod 8
            r2_hms  <= r1_hms;
        end
        if (w_en[2]) begin
            r3_year <= YEAR_1968 + {1'b0, r2_q4, 2'b00} + {6'd0, w_yoff};
            r3_yday <= w_yday;
            r3_leap <= w_leap;
            r3_wday <= r2_wday;
            r3_hms  <= r2_hms;
        end
        if (w_en[3]) begin
            r4_adj  <= w_adj;
            r4_mon  <= w_mon;
            r4_year <= r3_year;
            r4_yday <= r3_yday;
            r4_wday <= r3_wday;
            r4_hms  <= r3_hms;
        end
        if (w_en[4]) begin
            r5_cal.hms  <= r4_hms;
            r5_cal.wday <= r4_wday;
            r5_cal.year <= r4_year;
            r5_cal.yday <= r4_yday;
            r5_cal.mon  <= r4_mon;
            r5_cal.mday <= 5'(r4_adj - month_start(r4_mon) + 9'd1);
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[NSTG-1];
    assign o_cal   = r5_cal;

endmodule

// File: hdl/epoch_seconds_to_utc_calendar.sv
// Epoch seconds to UTC calendar: top level, time-of-day stages and handoff to the date pipeline.
// Depends on es2utc_pkg, es2utc_if and es2utc_date.
//
// Usage:
//   i_in carries one word per conversion: epoch_seconds, 31-bit unsigned seconds
//   since 1970-01-01 00:00:00 UTC. o_out returns second, minute, hour, weekday
//   (0 = Sunday), years_since_1900, day_of_year (0 = Jan 1), month_index (0 = Jan)
//   and day_of_month (from 1). Words move when valid and ready are both high.
//   A word passes four stages of reciprocal-multiply division by 60, 60 and 24,
//   then five stages that split the day count into 4-year and 1-year cycles and
//   look up the month. One word enters per cycle while o_out is not stalled; the
//   31x32 reciprocal multiply in the first stage is the widest unit. Each stage
//   advances when it is empty or the next one advances, so a stall on o_out fills
//   bubbles first and then holds all words in place; i_in.ready drops only when
//   every stage is full. Synchronous reset clears the valid bits; no other state
//   is kept.
module epoch_seconds_to_utc_calendar (
    input  logic          i_clk,
    input  logic          i_rst_n,
    es2utc_in_if.sink     i_in,
    es2utc_out_if.source  o_out
);
    import es2utc_pkg::*;

    localparam int NSTG = 4;

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] w_en;
    logic            w_date_ready;
    t_cal            w_cal;

    always_comb begin
        w_en[NSTG-1] = !r_v[NSTG-1] || w_date_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_in.valid;
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 1: total minutes
    logic [62:0] w_p1;
    logic [30:0] r1_x;
    logic [25:0] r1_q1;

    assign w_p1 = 63'(i_in.epoch_seconds) * 63'(C_DIV60_A);

    // stage 2: seconds, total hours
    logic [51:0] w_p2;
    logic [5:0]  r2_sec;
    logic [5:0]  r2_q1_lo;
    logic [19:0] r2_q2;

    assign w_p2 = 52'(r1_q1) * 52'(C_DIV60_B);

    // stage 3: minutes, total days
    logic [32:0]      w_p3;
    logic [5:0]       r3_sec;
    logic [5:0]       r3_min;
    logic [4:0]       r3_q2_lo;
    logic [DAY_W-1:0] r3_q3;

    assign w_p3 = 33'(r2_q2[19:3]) * 33'(C_DIV3);

    // stage 4: hours, day count rebased to 1968
    t_day_word r4_word;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_x  <= i_in.epoch_seconds;
            r1_q1 <= w_p1[62:S_DIV60_A];
        end
        // remainders taken mod 64 / mod 32: x - 60q == x + 4q (mod 64), x - 24q == x + 8q (mod 32)
        if (w_en[1]) begin
            r2_sec   <= r1_x[5:0] + {r1_q1[3:0], 2'b00};
            r2_q1_lo <= r1_q1[5:0];
            r2_q2    <= w_p2[50:S_DIV60_B];
        end
        if (w_en[2]) begin
            r3_sec   <= r2_sec;
            r3_min   <= r2_q1_lo + {r2_q2[3:0], 2'b00};
            r3_q2_lo <= r2_q2[4:0];
            r3_q3    <= w_p3[31:S_DIV3];
        end
        if (w_en[3]) begin
            r4_word.hms.sec <= r3_sec;
            r4_word.hms.min <= r3_min;
            r4_word.hms.hr  <= r3_q2_lo + {r3_q3[1:0], 3'b000};
            r4_word.days    <= r3_q3 + DAYS_1968_TO_1970;
        end
    end

    es2utc_date u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v[NSTG-1]),
        .o_ready (w_date_ready),
        .i_word  (r4_word),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_cal   (w_cal)
    );

    assign i_in.ready             = w_en[0];
    assign o_out.second           = w_cal.hms.sec;
    assign o_out.minute           = w_cal.hms.min;
    assign o_out.hour             = w_cal.hms.hr;
    assign o_out.weekday          = w_cal.wday;
    assign o_out.years_since_1900 = w_cal.year;
    assign o_out.day_of_year      = w_cal.yday;
    assign o_out.month_index      = w_cal.mon;
    assign o_out.day_of_month     = w_cal.mday;

endmodule

// File: test/es2utc_calendar_checker.sv
// Watches both channels of the epoch-to-calendar block, predicts each calendar word
// and compares it with what comes out. Depends on es2utc_pkg and es2utc_if.
module es2utc_calendar_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    es2utc_in_if  i_in_mon,
    es2utc_out_if i_out_mon,
    output int    o_errors,
    output int    o_pending,
    output int    o_converted,
    output int    o_input_stalls
);
    timeunit 1ns;
    timeprecision 1ps;

    import es2utc_pkg::*;

    typedef struct packed {
        logic [30:0] epoch;
        t_cal        cal;
    } t_dated_word;

    // month lengths with February at 29; December never needs an entry
    localparam int unsigned MONTH_DAYS [0:10] = '{31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30};

    localparam int unsigned DAYS_0001_TO_1970 = 719162;
    localparam int unsigned DAYS_400Y         = 146097;
    localparam int unsigned DAYS_399Y         = 145731;
    localparam int unsigned DAYS_100Y         = 36524;
    localparam int unsigned DAYS_99Y          = 36159;
    localparam int unsigned DAYS_4Y           = 1461;
    localparam int unsigned DAYS_3Y           = 1095;
    localparam int unsigned DAYS_1Y           = 365;

    t_dated_word expected_dates [$];

    // Gregorian breakdown, counting cycles from 0001-01-01 (a Monday)
    function automatic t_cal calendar_of_epoch(input logic [30:0] epoch);
        t_cal        c;
        int unsigned secs;
        int unsigned days;
        int unsigned year;
        int unsigned yday;
        int unsigned extra;
        int unsigned mon;
        int          leap;
        secs     = epoch;
        c.hms.sec = 6'(secs % 60);
        secs     = secs / 60;
        c.hms.min = 6'(secs % 60);
        secs     = secs / 60;
        c.hms.hr  = 5'(secs % 24);
        days     = secs / 24 + DAYS_0001_TO_1970;
        c.wday   = 3'((days + 1) % 7);
        leap     = 0;
        extra    = 0;
        year     = (days / DAYS_400Y) * 400;
        days     = days % DAYS_400Y;
        if (days >= DAYS_399Y) begin
            leap++;
            // Dec 31 of a leap century year
            if (days == DAYS_400Y - 1) begin
                days--;
                extra++;
            end
        end
        year = year + (days / DAYS_100Y) * 100;
        days = days % DAYS_100Y;
        if (days >= DAYS_99Y) leap--;
        year = year + (days / DAYS_4Y) * 4;
        days = days % DAYS_4Y;
        if (days >= DAYS_3Y) begin
            leap++;
            // Dec 31 of an ordinary leap year
            if (days == DAYS_4Y - 1) begin
                days--;
                extra++;
            end
        end
        year   = year + days / DAYS_1Y;
        yday   = days % DAYS_1Y + extra;
        c.year = 8'(year + 1 - 1900);
        c.yday = 9'(yday);
        days   = yday;
        // skip Feb 29 in common years
        if (leap == 0 && days >= 59) days++;
        mon = 0;
        while (mon < 11 && days >= MONTH_DAYS[mon]) begin
            days = days - MONTH_DAYS[mon];
            mon++;
        end
        c.mon  = 4'(mon);
        c.mday = 5'(days + 1);
        return c;
    endfunction

    function automatic bit field_ok(input string name, input logic [30:0] epoch,
                                    input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch for epoch %0d: expected %0d, actual %0d",
                     $time, name, epoch, want, got);
            return 0;
        end
        return 1;
    endfunction

    always @(posedge i_clk) begin : watch
        t_dated_word want;
        t_dated_word fresh;
        bit          ok;
        if (!i_rst_n) begin
            expected_dates.delete();
            o_errors       <= 0;
            o_pending      <= 0;
            o_converted    <= 0;
            o_input_stalls <= 0;
        end else begin
            // pop before push: a word entering now can never leave in the same cycle
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_dates.size() == 0) begin
                    $display({"%0t ns: calendar word with nothing expected: ",
                              "expected none, actual %0d-%0d-%0d"},
                             $time, i_out_mon.years_since_1900, i_out_mon.month_index,
                             i_out_mon.day_of_month);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_dates.pop_front();
                    ok = 1;
                    ok &= field_ok("second", want.epoch, want.cal.hms.sec, i_out_mon.second);
                    ok &= field_ok("minute", want.epoch, want.cal.hms.min, i_out_mon.minute);
                    ok &= field_ok("hour", want.epoch, want.cal.hms.hr, i_out_mon.hour);
                    ok &= field_ok("weekday", want.epoch, want.cal.wday, i_out_mon.weekday);
                    ok &= field_ok("years_since_1900", want.epoch, want.cal.year,
                                   i_out_mon.years_since_1900);
                    ok &= field_ok("day_of_year", want.epoch, want.cal.yday,
                                   i_out_mon.day_of_year);
                    ok &= field_ok("month_index", want.epoch, want.cal.mon,
                                   i_out_mon.month_index);
                    ok &= field_ok("day_of_month", want.epoch, want.cal.mday,
                                   i_out_mon.day_of_month);
                    if (!ok) o_errors <= o_errors + 1;
                    o_converted <= o_converted + 1;
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                fresh.epoch = i_in_mon.epoch_seconds;
                fresh.cal   = calendar_of_epoch(i_in_mon.epoch_seconds);
                expected_dates.push_back(fresh);
            end
            if (i_in_mon.valid && !i_in_mon.ready) o_input_stalls <= o_input_stalls + 1;
            o_pending <= expected_dates.size();
        end
    end

endmodule

// File: test/testbench.sv
// Top of the epoch-to-calendar testbench: clock, reset, stimulus and verdict.
// Depends on es2utc_pkg, es2utc_if, the block itself and es2utc_calendar_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {SINK_OPEN, SINK_PATTERN, SINK_RANDOM, SINK_HEAVY} t_sink_mode;

    localparam int RANDOM_WORDS = 700;
    localparam int HOLD_CYCLES  = 64;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;

    logic i_clk;
    logic i_rst_n;
    int   cycles;
    int   errors;
    int   pending;
    int   converted;
    int   input_stalls;
    int   directed_words;
    int   boundary_words;
    int   holds_done;

    es2utc_in_if  in_ch();
    es2utc_out_if out_ch();

    epoch_seconds_to_utc_calendar u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    es2utc_calendar_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_mon      (in_ch),
        .i_out_mon     (out_ch),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_converted   (converted),
        .o_input_stalls(input_stalls)
    );

    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.epoch_seconds = '0;
        out_ch.ready       = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected", cycles, pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic bit is_leap(input int year);
        return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
    endfunction

    // seconds since the epoch for a given year, day of year and second of day
    function automatic logic [30:0] epoch_at(input int year, input int yday, input int tod);
        longint days;
        days = yday;
        for (int y = 1970; y < year; y++) days += is_leap(y) ? 366 : 365;
        return 31'(days * 86400 + tod);
    endfunction

    // a day that sits on a year or February edge, at an edge or random time of day
    function automatic logic [30:0] boundary_epoch();
        int year;
        int yday;
        int tod;
        year = $urandom_range(1970, 2037);
        case ($urandom_range(0, 4))
            0:       yday = 0;
            1:       yday = 58;
            2:       yday = 59;
            3:       yday = 60;
            default: yday = is_leap(year) ? 365 : 364;
        endcase
        case ($urandom_range(0, 2))
            0:       tod = 0;
            1:       tod = 86399;
            default: tod = $urandom_range(0, 86399);
        endcase
        return epoch_at(year, yday, tod);
    endfunction

    function automatic logic [30:0] random_epoch();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) return 31'($urandom);
        if (pick < 9) begin
            boundary_words++;
            return boundary_epoch();
        end
        return 31'h7FFF_FFFF - 31'($urandom_range(0, 100000));
    endfunction

    task automatic send_epoch(input logic [30:0] epoch);
        @(negedge i_clk);
        in_ch.valid         <= 1'b1;
        in_ch.epoch_seconds <= epoch;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            in_ch.valid         <= 1'b0;
            in_ch.epoch_seconds <= 31'($urandom);
        end
    endtask

    // sink: stall patterns of its own, and long hold-offs so the pipe backs up
    initial begin : sink
        t_sink_mode  mode;
        int          span;
        logic [31:0] pattern;
        int          next_hold;
        next_hold  = 100;
        holds_done = 0;
        @(posedge i_rst_n);
        forever begin
            mode    = t_sink_mode'($urandom_range(0, 3));
            span    = $urandom_range(20, 120);
            pattern = $urandom;
            for (int k = 0; k < span; k++) begin
                @(negedge i_clk);
                case (mode)
                    SINK_OPEN:    out_ch.ready <= 1'b1;
                    SINK_PATTERN: out_ch.ready <= pattern[k % 32];
                    SINK_RANDOM:  out_ch.ready <= ($urandom_range(0, 3) != 0);
                    SINK_HEAVY:   out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:      out_ch.ready <= 1'b1;
                endcase
            end
            if (converted >= next_hold) begin
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    out_ch.ready <= 1'b0;
                end
                holds_done++;
                next_hold += 250;
            end
        end
    end

    initial begin : source
        logic [30:0] directed [$];
        int          sent;
        int          burst;
        cycles         = 0;
        boundary_words = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed = '{31'd0, 31'd1, 31'd59, 31'd60, 31'd3599, 31'd3600, 31'd86399, 31'd86400,
                     31'h7FFF_FFFF, 31'h5555_5555, 31'h2AAA_AAAA,
                     epoch_at(1970, 58, 86399),   // Feb 28 of a common year
                     epoch_at(1970, 59, 0),       // Mar 1 of a common year
                     epoch_at(1972, 59, 43200),   // Feb 29
                     epoch_at(1972, 60, 0),
                     epoch_at(1972, 365, 86399),  // last day of a four-year cycle
                     epoch_at(1973, 0, 0),
                     epoch_at(1999, 364, 86399),
                     epoch_at(2000, 59, 3661),    // Feb 29 of a leap century
                     epoch_at(2000, 365, 86399),  // last day of a 400-year cycle
                     epoch_at(2001, 0, 0),
                     epoch_at(2037, 364, 86399)};
        directed_words = directed.size();
        foreach (directed[i]) begin
            send_epoch(directed[i]);
            if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 3));
        end

        sent = 0;
        while (sent < RANDOM_WORDS) begin
            burst = $urandom_range(1, 24);
            for (int j = 0; j < burst && sent < RANDOM_WORDS; j++) begin
                send_epoch(random_epoch());
                sent++;
            end
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
        end
        idle_cycles(1);

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("converted %0d timestamps: %0d directed, %0d random (%0d on calendar edges)",
                 converted, directed_words, RANDOM_WORDS, boundary_words);
        $display("input stalled %0d cycles under sink back-pressure, %0d long hold-offs",
                 input_stalls, holds_done);
        if (errors == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/es2utc_pkg.sv
hdl/es2utc_if.sv
hdl/es2utc_date.sv
hdl/epoch_seconds_to_utc_calendar.sv
test/es2utc_calendar_checker.sv
test/testbench.sv
